>>> src/ndpl_pkg.sv
// ----------------------------------------------------------------------------
// ndpl_pkg
// Shared types and constants of the nearest-neighbor downscaler with preview
// and luma outputs.
// ----------------------------------------------------------------------------
package ndpl_pkg;

  localparam int DIM_BITS   = 14;
  localparam int CHAN_BITS  = 16;
  localparam int ACC_BITS   = 30;
  localparam int PICK_BITS  = DIM_BITS + 1;
  localparam int SCALE_NUM_W = 2 * DIM_BITS + 1;
  localparam int DIV_NUM_W  = (SCALE_NUM_W > ACC_BITS) ? SCALE_NUM_W : ACC_BITS;
  localparam int DIV_DEN_W  = DIM_BITS + 1;
  localparam int DIV_LEN_W  = $clog2(DIV_NUM_W + 1);
  localparam int MUL_W      = 16;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int LUMA_W     = 24;
  localparam int LUMA_FRAC  = 8;

  localparam logic [MUL_W-1:0] LUMA_COEF_R = 16'd13933;
  localparam logic [MUL_W-1:0] LUMA_COEF_G = 16'd46871;
  localparam logic [MUL_W-1:0] LUMA_COEF_B = 16'd4732;
  localparam logic [PROD_W-1:0] LUMA_ROUND = PROD_W'(128);

  // A 16-bit channel divided by 257 is exactly (x * 65281) >> 24.
  localparam logic [MUL_W-1:0] RECIP_257 = 16'hFF01;
  localparam int QUO_LSB = 24;
  localparam logic [DIV_LEN_W-1:0] FULL_DIV_LEN = DIV_LEN_W'(DIV_NUM_W);
  localparam logic [7:0] ARGB_ALPHA = 8'hFF;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIDE_SAMPLES = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PREVIEW_EDGE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ALIGN_EDGE   = 3'd4;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red_in;
    logic [CHAN_BITS-1:0] green_in;
    logic [CHAN_BITS-1:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] full_red;
    logic [CHAN_BITS-1:0] full_green;
    logic [CHAN_BITS-1:0] full_blue;
    logic                 preview_valid;
    logic [31:0]          preview_word;
    logic                 align_valid;
    logic [LUMA_W-1:0]    align_luma;
    logic                 frame_last;
  } res_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_LEN_W-1:0] len;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

>>> src/ndpl_pix_if.sv
// ----------------------------------------------------------------------------
// ndpl_pix_if
// Valid/ready channel that carries one RGB input pixel per transfer.
// ----------------------------------------------------------------------------
interface ndpl_pix_if;
  logic          valid;
  logic          ready;
  ndpl_pkg::pix_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/ndpl_res_if.sv
// ----------------------------------------------------------------------------
// ndpl_res_if
// Valid/ready channel that carries one result item per transfer.
// ----------------------------------------------------------------------------
interface ndpl_res_if;
  logic          valid;
  logic          ready;
  ndpl_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/ndpl_div.sv
// ----------------------------------------------------------------------------
// ndpl_div
// Shared restoring divider that retires one quotient bit per cycle. The
// numerator is left-aligned and len gives the number of bits to process.
// ----------------------------------------------------------------------------
module ndpl_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ndpl_pkg::div_req_t              req,
  input  logic [ndpl_pkg::DIV_NUM_W-1:0]  num,
  input  logic [ndpl_pkg::DIV_DEN_W-1:0]  den,
  output ndpl_pkg::div_rsp_t              rsp,
  output logic [ndpl_pkg::DIV_NUM_W-1:0]  quot
);

  logic [ndpl_pkg::DIV_LEN_W-1:0] cnt_r;
  logic                           done_r;
  logic [ndpl_pkg::DIV_NUM_W-1:0] num_r;
  logic [ndpl_pkg::DIV_NUM_W-1:0] quot_r;
  logic [ndpl_pkg::DIV_DEN_W-1:0] den_r;
  logic [ndpl_pkg::DIV_DEN_W-1:0] rem_r;
  logic [ndpl_pkg::DIV_DEN_W-1:0] rem_nxt;
  logic [ndpl_pkg::DIV_DEN_W:0]   trial;
  logic [ndpl_pkg::DIV_DEN_W:0]   diff;
  logic                           qbit;

  assign trial   = {rem_r, num_r[ndpl_pkg::DIV_NUM_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign qbit    = trial >= {1'b0, den_r};
  assign rem_nxt = qbit ? diff[ndpl_pkg::DIV_DEN_W-1:0] : trial[ndpl_pkg::DIV_DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == ndpl_pkg::DIV_LEN_W'(1));
      if (req.start) begin
        cnt_r  <= req.len;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quot_r <= '0;
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        num_r  <= {num_r[ndpl_pkg::DIV_NUM_W-2:0], 1'b0};
        rem_r  <= rem_nxt;
        quot_r <= {quot_r[ndpl_pkg::DIV_NUM_W-2:0], qbit};
      end
    end
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;
  assign quot     = quot_r;

endmodule

>>> src/nearest_downscale_preview_luma.sv
// ----------------------------------------------------------------------------
// nearest_downscale_preview_luma
// Nearest-neighbor downscaler that passes RGB pixels through at 16 bits per
// channel and marks the pixels chosen for a preview and an alignment image.
// ----------------------------------------------------------------------------
// Pixels enter on in_pix in raster order and each gives a result on
// out_res. The frame size, sample width and both edge limits are written
// through the APB port; the user must write them only between pixels, as
// the block itself does not enforce this. At the first pixel of a frame the
// block computes the preview and alignment sizes, keeping width and height
// if the longer edge fits the limit, else scaling both. Each pixel is then
// handled with one shared multiplier and one shared bit-serial divider: an
// alignment pixel adds a luma multiply-accumulate, a preview pixel adds three
// reciprocal multiplies for the division by 257, and each pick index it
// advances adds a division. The divider sets the scale and pick figures. The
// result becomes valid in the same cycle that the block is ready again. It
// sits in an output register, so the next pixel is accepted while it waits.
// A stalled receiver only holds up the block once a new result is ready to
// replace the waiting one. Reset loads the register defaults, clears the
// position and the picks and empties the output register.
// ----------------------------------------------------------------------------
module nearest_downscale_preview_luma (
  input  logic                             clk,
  input  logic                             rst_n,
  ndpl_pix_if.sink                         in_pix,
  ndpl_res_if.source                       out_res,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ndpl_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ndpl_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ndpl_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int DB = ndpl_pkg::DIM_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCALE, ST_SLOAD, ST_SDIV, ST_PIX, ST_MAC,
    ST_QUO, ST_QDIV, ST_PICK, ST_PDIV, ST_FIN
  } state_t;

  state_t state_r;

  logic [DB-1:0] img_w_r, img_h_r, prev_lim_r, align_lim_r;
  logic          wide_r;

  logic [DB-1:0] col_r, row_r;
  logic [DB-1:0] dims_r [4];
  logic [ndpl_pkg::PICK_BITS-1:0] picks_r [4];
  logic [ndpl_pkg::ACC_BITS-1:0]  acc_r [4];

  logic [ndpl_pkg::CHAN_BITS-1:0] red_r, grn_r, blu_r;
  logic [7:0]  q_r [3];
  logic [ndpl_pkg::PROD_W-1:0] mul_r, luma_r;
  logic [1:0]  scale_k_r, mac_k_r, chan_k_r, pick_k_r;
  logic        pcol_r, prow_r, acol_r, arow_r, last_col_r, last_row_r;
  logic        pv_r, av_r;

  logic          out_valid_r;
  ndpl_pkg::res_t out_r;

  logic [DB-1:0] w, h, pm, am, longest, dim_sel, lim_sel, pick_src;
  logic          first_px, fits, pick_en, fin_go, cfg_wr, in_go;
  logic [ndpl_pkg::MUL_W-1:0] mul_a, mul_b;
  logic [ndpl_pkg::CHAN_BITS-1:0] chan_sel;
  logic [ndpl_pkg::ACC_BITS-1:0]  acc_nxt;
  logic [DB:0]   col_inc, row_inc;

  ndpl_pkg::div_req_t div_req;
  ndpl_pkg::div_rsp_t div_rsp;
  logic [ndpl_pkg::DIV_NUM_W-1:0] div_num, div_quot;
  logic [ndpl_pkg::DIV_DEN_W-1:0] div_den;
  logic [DB-1:0] scale_q;
  logic [ndpl_pkg::PICK_BITS-1:0] pick_q;

  function automatic logic [ndpl_pkg::CHAN_BITS-1:0] widen(
    input logic [ndpl_pkg::CHAN_BITS-1:0] v, input logic wide);
    return wide ? v : {v[7:0], v[7:0]};
  endfunction

  assign w  = (img_w_r == '0) ? DB'(1) : img_w_r;
  assign h  = (img_h_r == '0) ? DB'(1) : img_h_r;
  assign pm = (prev_lim_r == '0) ? DB'(1) : prev_lim_r;
  assign am = (align_lim_r == '0) ? DB'(1) : align_lim_r;
  assign longest = (w > h) ? w : h;
  assign dim_sel = scale_k_r[0] ? h : w;
  assign lim_sel = scale_k_r[1] ? am : pm;
  assign fits    = longest <= lim_sel;
  assign first_px = (col_r == '0) && (row_r == '0);
  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign in_pix.ready = (state_r == ST_IDLE);
  assign in_go = in_pix.valid && (state_r == ST_IDLE);
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_res.ready);

  always_comb begin
    unique case (paddr[4:2])
      ndpl_pkg::REG_IMAGE_WIDTH:  prdata = ndpl_pkg::APB_DATA_W'(img_w_r);
      ndpl_pkg::REG_IMAGE_HEIGHT: prdata = ndpl_pkg::APB_DATA_W'(img_h_r);
      ndpl_pkg::REG_WIDE_SAMPLES: prdata = ndpl_pkg::APB_DATA_W'(wide_r);
      ndpl_pkg::REG_PREVIEW_EDGE: prdata = ndpl_pkg::APB_DATA_W'(prev_lim_r);
      ndpl_pkg::REG_ALIGN_EDGE:   prdata = ndpl_pkg::APB_DATA_W'(align_lim_r);
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    case (chan_k_r)
      2'd0:    chan_sel = red_r;
      2'd1:    chan_sel = grn_r;
      default: chan_sel = blu_r;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_SCALE) begin
      mul_a = ndpl_pkg::MUL_W'(dim_sel);
      mul_b = ndpl_pkg::MUL_W'(lim_sel);
    end else if (state_r == ST_QUO) begin
      mul_a = chan_sel;
      mul_b = ndpl_pkg::RECIP_257;
    end else if (state_r == ST_MAC) begin
      case (mac_k_r)
        2'd0: begin
          mul_a = red_r;
          mul_b = ndpl_pkg::LUMA_COEF_R;
        end
        2'd1: begin
          mul_a = grn_r;
          mul_b = ndpl_pkg::LUMA_COEF_G;
        end
        2'd2: begin
          mul_a = blu_r;
          mul_b = ndpl_pkg::LUMA_COEF_B;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_comb begin
    case (pick_k_r)
      2'd0:    pick_en = pcol_r && !last_col_r;
      2'd1:    pick_en = last_col_r && prow_r;
      2'd2:    pick_en = acol_r && !last_col_r;
      default: pick_en = last_col_r && arow_r;
    endcase
  end

  assign pick_src = pick_k_r[0] ? h : w;
  assign acc_nxt  = acc_r[pick_k_r] + ndpl_pkg::ACC_BITS'(pick_src);

  always_comb begin
    div_req.start = 1'b0;
    div_req.len   = ndpl_pkg::FULL_DIV_LEN;
    div_num       = '0;
    div_den       = '0;
    unique case (state_r)
      ST_SLOAD: begin
        div_req.start = 1'b1;
        div_num = (ndpl_pkg::DIV_NUM_W'(mul_r) << 1) + ndpl_pkg::DIV_NUM_W'(longest);
        div_den = {longest, 1'b0};
      end
      ST_PICK: begin
        div_req.start = pick_en;
        div_num = ndpl_pkg::DIV_NUM_W'(acc_nxt);
        div_den = ndpl_pkg::DIV_DEN_W'(dims_r[pick_k_r]);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  assign scale_q = (div_quot == '0) ? DB'(1) : div_quot[DB-1:0];
  assign pick_q  = {|div_quot[ndpl_pkg::DIV_NUM_W-1:DB], div_quot[DB-1:0]};

  ndpl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .den   (div_den),
    .rsp   (div_rsp),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      img_w_r     <= DB'(1);
      img_h_r     <= DB'(1);
      wide_r      <= 1'b1;
      prev_lim_r  <= DB'(1024);
      align_lim_r <= DB'(512);
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        picks_r[k] <= '0;
        acc_r[k]   <= '0;
      end
    end else begin
      mul_r <= mul_a * mul_b;
      if (cfg_wr) begin
        unique case (paddr[4:2])
          ndpl_pkg::REG_IMAGE_WIDTH:  img_w_r     <= pwdata[DB-1:0];
          ndpl_pkg::REG_IMAGE_HEIGHT: img_h_r     <= pwdata[DB-1:0];
          ndpl_pkg::REG_WIDE_SAMPLES: wide_r      <= pwdata[0];
          ndpl_pkg::REG_PREVIEW_EDGE: prev_lim_r  <= pwdata[DB-1:0];
          ndpl_pkg::REG_ALIGN_EDGE:   align_lim_r <= pwdata[DB-1:0];
          default: ;
        endcase
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_go) begin
            red_r     <= widen(in_pix.payload.red_in, wide_r);
            grn_r     <= widen(in_pix.payload.green_in, wide_r);
            blu_r     <= widen(in_pix.payload.blue_in, wide_r);
            scale_k_r <= 2'd0;
            if (first_px) begin
              for (int k = 0; k < 4; k++) begin
                picks_r[k] <= '0;
                acc_r[k]   <= '0;
              end
              state_r <= ST_SCALE;
            end else begin
              state_r <= ST_PIX;
            end
          end
        end
        ST_SCALE: begin
          if (fits) begin
            dims_r[scale_k_r] <= dim_sel;
            scale_k_r <= scale_k_r + 1'b1;
            state_r <= (scale_k_r == 2'd3) ? ST_PIX : ST_SCALE;
          end else begin
            state_r <= ST_SLOAD;
          end
        end
        ST_SLOAD: begin
          state_r <= ST_SDIV;
        end
        ST_SDIV: begin
          if (div_rsp.done) begin
            dims_r[scale_k_r] <= scale_q;
            scale_k_r <= scale_k_r + 1'b1;
            state_r <= (scale_k_r == 2'd3) ? ST_PIX : ST_SCALE;
          end
        end
        ST_PIX: begin
          pcol_r     <= {1'b0, col_r} == picks_r[0];
          prow_r     <= {1'b0, row_r} == picks_r[1];
          acol_r     <= {1'b0, col_r} == picks_r[2];
          arow_r     <= {1'b0, row_r} == picks_r[3];
          last_col_r <= col_inc >= {1'b0, w};
          last_row_r <= row_inc >= {1'b0, h};
          pv_r <= ({1'b0, col_r} == picks_r[0]) &&
                  ({1'b0, row_r} == picks_r[1]);
          av_r <= ({1'b0, col_r} == picks_r[2]) &&
                  ({1'b0, row_r} == picks_r[3]);
          luma_r   <= ndpl_pkg::LUMA_ROUND;
          mac_k_r  <= 2'd0;
          chan_k_r <= 2'd0;
          pick_k_r <= 2'd0;
          state_r  <= (({1'b0, col_r} == picks_r[2]) && ({1'b0, row_r} == picks_r[3])) ?
                      ST_MAC : ST_QUO;
        end
        ST_MAC: begin
          if (mac_k_r != 2'd0) begin
            luma_r <= luma_r + mul_r;
          end
          mac_k_r <= mac_k_r + 1'b1;
          if (mac_k_r == 2'd3) begin
            state_r <= ST_QUO;
          end
        end
        ST_QUO: begin
          state_r <= pv_r ? ST_QDIV : ST_PICK;
        end
        ST_QDIV: begin
          q_r[chan_k_r] <= mul_r[ndpl_pkg::QUO_LSB +: 8];
          chan_k_r <= chan_k_r + 1'b1;
          state_r <= (chan_k_r == 2'd2) ? ST_PICK : ST_QUO;
        end
        ST_PICK: begin
          if (pick_en) begin
            acc_r[pick_k_r] <= acc_nxt;
            state_r <= ST_PDIV;
          end else begin
            pick_k_r <= pick_k_r + 1'b1;
            state_r <= (pick_k_r == 2'd3) ? ST_FIN : ST_PICK;
          end
        end
        ST_PDIV: begin
          if (div_rsp.done) begin
            picks_r[pick_k_r] <= pick_q;
            pick_k_r <= pick_k_r + 1'b1;
            state_r <= (pick_k_r == 2'd3) ? ST_FIN : ST_PICK;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            out_r.full_red      <= red_r;
            out_r.full_green    <= grn_r;
            out_r.full_blue     <= blu_r;
            out_r.preview_valid <= pv_r;
            out_r.align_valid   <= av_r;
            out_r.preview_word  <= pv_r ?
                                   {ndpl_pkg::ARGB_ALPHA, q_r[0], q_r[1], q_r[2]} : '0;
            out_r.align_luma    <= av_r ?
                                   luma_r[ndpl_pkg::LUMA_FRAC +: ndpl_pkg::LUMA_W] : '0;
            out_r.frame_last    <= last_col_r && last_row_r;
            if (last_col_r) begin
              picks_r[0] <= '0;
              picks_r[2] <= '0;
              acc_r[0]   <= '0;
              acc_r[2]   <= '0;
              col_r      <= '0;
              row_r      <= last_row_r ? '0 : row_inc[DB-1:0];
            end else begin
              col_r <= col_inc[DB-1:0];
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.payload = out_r;

  // The divider is never restarted while it still works on a quotient.
  a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A new result only appears from the final step of the sequence.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result appeared outside the final step");

  // Scaled sizes are never zero once a pixel is evaluated.
  a_dims_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PIX) |->
      (dims_r[0] != '0 && dims_r[1] != '0 && dims_r[2] != '0 && dims_r[3] != '0))
    else $error("scaled size is zero");

  // After the last pixel of a frame the position returns to the origin.
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && last_col_r && last_row_r) |=> (col_r == '0 && row_r == '0))
    else $error("position not cleared at frame end");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-neighbor downscaler with preview and
// luma outputs. A short directed table covers reset defaults, extreme frame
// sizes and limits, zero-valued registers, narrow samples and register
// changes in the middle of a frame. Random frames follow, mostly small and
// complete, with some broken and some huge ones. Every result is checked
// fieldwise, typed pixels against written values and the rest against a
// predictor of frame position and picks. Both channel sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RANDOM_PIXELS = 1900;
  localparam longint unsigned COEF_R = 13933;
  localparam longint unsigned COEF_G = 46871;
  localparam longint unsigned COEF_B = 4732;
  localparam logic [13:0] DIM_MAX = 14'h3FFF;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [ndpl_pkg::REG_IDX_W-1:0]  reg_idx;
    logic [13:0]                     value;
    ndpl_pkg::pix_t                  pixel;
    bit                              typed;
    ndpl_pkg::res_t                  want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ndpl_pkg::APB_ADDR_W-1:0] paddr;
  logic [ndpl_pkg::APB_DATA_W-1:0] pwdata;
  logic [ndpl_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  ndpl_pix_if pix_ch ();
  ndpl_res_if res_ch ();

  nearest_downscale_preview_luma dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch),
    .out_res (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ndpl_pkg::res_t pending_results[$];
  stim_row_t      plan[$];
  int unsigned    mismatch_count;
  bit             no_idle;

  logic [13:0] sh_width;
  logic [13:0] sh_height;
  logic        sh_wide;
  logic [13:0] sh_pv_limit;
  logic [13:0] sh_al_limit;

  int unsigned cur_col;
  int unsigned cur_row;
  int unsigned target_size[4];
  int unsigned next_pick[4];
  int unsigned pick_sum[4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(60_000_000);
    $display("== FAIL ==");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic int unsigned fit_edge(input int unsigned dim, input int unsigned limit,
                                           input int unsigned longest);
    longint unsigned q;
    if (longest <= limit) return dim;
    q = (2 * longint'(dim) * longint'(limit) + longint'(longest)) / (2 * longint'(longest));
    return (q == 0) ? 1 : int'(q);
  endfunction

  function automatic void step_pick(input int k, input int unsigned src);
    pick_sum[k] = (pick_sum[k] + src) & 32'h3FFF_FFFF;
    next_pick[k] = (target_size[k] == 0) ? 32'hFFFF_FFFF : pick_sum[k] / target_size[k];
  endfunction

  function automatic logic [15:0] widen_sample(input logic [15:0] s);
    return sh_wide ? s : 16'(s[7:0]) * 16'd257;
  endfunction

  function automatic ndpl_pkg::res_t scale_and_pick(input ndpl_pkg::pix_t p);
    ndpl_pkg::res_t o;
    int unsigned w, h, longest, pm, am;
    logic [15:0] r, g, b;
    bit pcol, prow, acol, arow, last_col, last_row;
    longint unsigned y;
    w = (sh_width == 0) ? 1 : sh_width;
    h = (sh_height == 0) ? 1 : sh_height;
    if (cur_col == 0 && cur_row == 0) begin
      longest = (w > h) ? w : h;
      pm = (sh_pv_limit == 0) ? 1 : sh_pv_limit;
      am = (sh_al_limit == 0) ? 1 : sh_al_limit;
      target_size[0] = fit_edge(w, pm, longest);
      target_size[1] = fit_edge(h, pm, longest);
      target_size[2] = fit_edge(w, am, longest);
      target_size[3] = fit_edge(h, am, longest);
      for (int k = 0; k < 4; k++) begin
        next_pick[k] = 0;
        pick_sum[k] = 0;
      end
    end
    r = widen_sample(p.red_in);
    g = widen_sample(p.green_in);
    b = widen_sample(p.blue_in);
    pcol = (cur_col == next_pick[0]);
    prow = (cur_row == next_pick[1]);
    acol = (cur_col == next_pick[2]);
    arow = (cur_row == next_pick[3]);
    last_col = (cur_col + 1 >= w);
    last_row = (cur_row + 1 >= h);
    y = (COEF_R * r + COEF_G * g + COEF_B * b + 128) >> 8;
    o.full_red = r;
    o.full_green = g;
    o.full_blue = b;
    o.preview_valid = pcol && prow;
    o.preview_word = (pcol && prow) ?
                     {8'hFF, 8'(r / 16'd257), 8'(g / 16'd257), 8'(b / 16'd257)} : 32'h0;
    o.align_valid = acol && arow;
    o.align_luma = (acol && arow) ? y[23:0] : 24'h0;
    o.frame_last = last_col && last_row;
    if (pcol) step_pick(0, w);
    if (acol) step_pick(2, w);
    if (last_col) begin
      if (prow) step_pick(1, h);
      if (arow) step_pick(3, h);
      next_pick[0] = 0;
      pick_sum[0] = 0;
      next_pick[2] = 0;
      pick_sum[2] = 0;
      cur_col = 0;
      cur_row = last_row ? 0 : ((cur_row + 1) & 32'h3FFF);
    end else begin
      cur_col = (cur_col + 1) & 32'h3FFF;
    end
    return o;
  endfunction

  task automatic wait_idle();
    pix_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic apb_write(input logic [ndpl_pkg::REG_IDX_W-1:0] idx,
                           input logic [13:0] value);
    logic [31:0] mask;
    mask = (idx == ndpl_pkg::REG_WIDE_SAMPLES) ? 32'h1 : 32'h3FFF;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== (32'(value) & mask)) begin
      note_mismatch($sformatf("register %0d read back %h, expected %h",
                              idx, prdata, 32'(value) & mask));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      ndpl_pkg::REG_IMAGE_WIDTH: begin
        sh_width = value;
      end
      ndpl_pkg::REG_IMAGE_HEIGHT: begin
        sh_height = value;
      end
      ndpl_pkg::REG_WIDE_SAMPLES: begin
        sh_wide = value[0];
      end
      ndpl_pkg::REG_PREVIEW_EDGE: begin
        sh_pv_limit = value;
      end
      ndpl_pkg::REG_ALIGN_EDGE: begin
        sh_al_limit = value;
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(input ndpl_pkg::pix_t p, input bit typed,
                            input ndpl_pkg::res_t want);
    int unsigned gap;
    ndpl_pkg::res_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.payload <= p;
    do @(posedge clk); while (!pix_ch.ready);
    predicted = scale_and_pick(p);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic add_write(input logic [ndpl_pkg::REG_IDX_W-1:0] idx,
                           input logic [13:0] value);
    stim_row_t row;
    row = '{kind: ROW_WRITE, reg_idx: idx, value: value, pixel: '0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endtask

  task automatic add_pixel(input ndpl_pkg::pix_t p, input bit typed = 1'b0,
                           input ndpl_pkg::res_t want = '0);
    stim_row_t row;
    row = '{kind: ROW_PIXEL, reg_idx: '0, value: '0, pixel: p, typed: typed, want: want};
    plan.push_back(row);
  endtask

  function automatic logic [15:0] rand_channel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [13:0] rand_dim();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? DIM_MAX : 14'($urandom);
    return 14'($urandom_range(1, 12));
  endfunction

  function automatic logic [13:0] rand_limit();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? DIM_MAX : 14'($urandom);
    return 14'($urandom_range(1, 14));
  endfunction

  always @(posedge clk) begin : result_check
    ndpl_pkg::res_t want;
    ndpl_pkg::res_t got;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = pending_results.pop_front();
        if (got.full_red !== want.full_red || got.full_green !== want.full_green ||
            got.full_blue !== want.full_blue || got.preview_valid !== want.preview_valid ||
            got.preview_word !== want.preview_word || got.align_valid !== want.align_valid ||
            got.align_luma !== want.align_luma || got.frame_last !== want.frame_last) begin
          note_mismatch($sformatf(
            "expected rgb %h %h %h pv %b word %h av %b luma %h last %b",
            want.full_red, want.full_green, want.full_blue, want.preview_valid,
            want.preview_word, want.align_valid, want.align_luma, want.frame_last));
          if (mismatch_count <= 10) begin
            $display("actual   rgb %h %h %h pv %b word %h av %b luma %h last %b",
                     got.full_red, got.full_green, got.full_blue, got.preview_valid,
                     got.preview_word, got.align_valid, got.align_luma, got.frame_last);
          end
        end
      end
    end
  end

  initial begin : sink_side
    int unsigned stall;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  initial begin : source_side
    int unsigned sent;
    int unsigned count;
    int unsigned w;
    int unsigned h;
    int unsigned rest;
    ndpl_pkg::pix_t p;
    mismatch_count = 0;
    no_idle = 1'b0;
    sh_width = 14'd1;
    sh_height = 14'd1;
    sh_wide = 1'b1;
    sh_pv_limit = 14'd1024;
    sh_al_limit = 14'd512;
    cur_col = 0;
    cur_row = 0;
    for (int k = 0; k < 4; k++) begin
      target_size[k] = 0;
      next_pick[k] = 0;
      pick_sum[k] = 0;
    end
    rst_n <= 1'b0;
    pix_ch.valid <= 1'b0;
    pix_ch.payload <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_pixel('{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
              '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 24'hFFFF00, 1'b1});
    add_pixel('{16'h0000, 16'h0000, 16'h0000}, 1'b1,
              '{16'h0000, 16'h0000, 16'h0000, 1'b1, 32'hFF00_0000, 1'b1, 24'h000000, 1'b1});
    add_write(ndpl_pkg::REG_WIDE_SAMPLES, 14'd0);
    add_pixel('{16'hFF12, 16'h0034, 16'hFFFF});
    add_pixel('{16'hFF00, 16'h00FF, 16'h0100});
    add_write(ndpl_pkg::REG_IMAGE_WIDTH, 14'd0);
    add_write(ndpl_pkg::REG_IMAGE_HEIGHT, 14'd0);
    add_write(ndpl_pkg::REG_PREVIEW_EDGE, 14'd0);
    add_write(ndpl_pkg::REG_ALIGN_EDGE, 14'd0);
    add_pixel('{16'h5A5A, 16'hA5C3, 16'h3C81});
    add_write(ndpl_pkg::REG_WIDE_SAMPLES, 14'd1);
    add_write(ndpl_pkg::REG_IMAGE_WIDTH, DIM_MAX);
    add_write(ndpl_pkg::REG_IMAGE_HEIGHT, 14'd1);
    add_write(ndpl_pkg::REG_PREVIEW_EDGE, 14'd1);
    add_write(ndpl_pkg::REG_ALIGN_EDGE, DIM_MAX);
    add_pixel('{16'h8000, 16'h7FFF, 16'h0001});
    add_pixel('{16'h1234, 16'h5678, 16'h9ABC});
    add_pixel('{16'hFFFF, 16'h0000, 16'hFFFF});
    add_write(ndpl_pkg::REG_IMAGE_WIDTH, 14'd2);
    add_pixel('{16'h0F0F, 16'hF0F0, 16'h00FF});
    add_write(ndpl_pkg::REG_IMAGE_WIDTH, 14'd1);
    add_write(ndpl_pkg::REG_IMAGE_HEIGHT, DIM_MAX);
    add_write(ndpl_pkg::REG_PREVIEW_EDGE, DIM_MAX);
    add_write(ndpl_pkg::REG_ALIGN_EDGE, 14'd1);
    add_pixel('{16'hDEAD, 16'hBEEF, 16'hCAFE});
    add_pixel('{16'h0101, 16'h0202, 16'h0303});
    add_pixel('{16'hFFFE, 16'hFFFD, 16'hFFFC});
    add_write(ndpl_pkg::REG_IMAGE_HEIGHT, 14'd1);
    add_pixel('{16'h4000, 16'h2000, 16'h1000});
    add_write(ndpl_pkg::REG_IMAGE_WIDTH, 14'd3);
    add_write(ndpl_pkg::REG_IMAGE_HEIGHT, 14'd2);
    add_write(ndpl_pkg::REG_PREVIEW_EDGE, 14'd2);
    add_write(ndpl_pkg::REG_ALIGN_EDGE, 14'd1);
    for (int i = 0; i < 6; i++) begin
      add_pixel('{16'(i * 16'h2A2B), 16'(16'hFFFF - i * 16'h1111), 16'(i * 16'h0707)});
    end

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        apb_write(plan[i].reg_idx, plan[i].value);
      end else begin
        send_pixel(plan[i].pixel, plan[i].typed, plan[i].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      wait_idle();
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) apb_write(ndpl_pkg::REG_IMAGE_WIDTH, rand_dim());
      if ($urandom_range(0, 3) != 0) apb_write(ndpl_pkg::REG_IMAGE_HEIGHT, rand_dim());
      if ($urandom_range(0, 3) != 0) begin
        apb_write(ndpl_pkg::REG_WIDE_SAMPLES, 14'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) != 0) apb_write(ndpl_pkg::REG_PREVIEW_EDGE, rand_limit());
      if ($urandom_range(0, 3) != 0) apb_write(ndpl_pkg::REG_ALIGN_EDGE, rand_limit());
      w = (sh_width == 0) ? 1 : sh_width;
      h = (sh_height == 0) ? 1 : sh_height;
      if (w * h <= 300) begin
        if (cur_col == 0 && cur_row == 0) begin
          rest = 0;
        end else begin
          rest = ((cur_col + 1 >= w) ? 1 : w - cur_col) +
                 ((cur_row + 1 >= h) ? 0 : (h - cur_row - 1) * w);
        end
        count = rest + w * h * $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) count += $urandom_range(1, w * h);
      end else begin
        count = $urandom_range(1, 24);
      end
      repeat (count) begin
        if (sent < RANDOM_PIXELS) begin
          p.red_in = rand_channel();
          p.green_in = rand_channel();
          p.blue_in = rand_channel();
          send_pixel(p, 1'b0, '0);
          sent++;
        end
      end
    end

    wait_idle();
    repeat (400) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> nearest_downscale_preview_luma.f
src/ndpl_pkg.sv
src/ndpl_pix_if.sv
src/ndpl_res_if.sv
src/ndpl_div.sv
src/nearest_downscale_preview_luma.sv
verif/testbench.sv
